### rtl/rpfd_pkg.sv
// ----------------------------------------------------------------------------
// rpfd_pkg
// Shared constants and register codes of the rf pulse frame decoder.
// ----------------------------------------------------------------------------
package rpfd_pkg;

    // configuration port
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned CFG_IDX_W  = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BIT_THRESHOLD = 2'd0,
        REG_GAP_MIN       = 2'd1,
        REG_GAP_MAX       = 2'd2,
        REG_UNUSED        = 2'd3
    } t_reg_idx;

    // register reset values (gap bounds are 310 and 350 times a divider of 34)
    localparam logic [CFG_DATA_W-1:0] BIT_THRESHOLD_RST = 16'd837;
    localparam logic [CFG_DATA_W-1:0] GAP_MIN_RST       = 16'd10540;
    localparam logic [CFG_DATA_W-1:0] GAP_MAX_RST       = 16'd11900;

    // frame layout
    localparam int unsigned COUNT_W  = 6;
    localparam int unsigned GROUPS_N = 12;
    localparam int unsigned GROUP_W  = 4;
    localparam logic [COUNT_W-1:0] FRAME_PULSES = 6'd50;
    localparam logic [COUNT_W-1:0] COUNT_SAT    = 6'd51;
    localparam logic [GROUP_W-1:0] LAST_GROUP   = 4'd11;

    // result field widths
    localparam int unsigned ID_W   = 5;
    localparam int unsigned UNIT_W = 4;

endpackage

### rtl/rpfd_in_if.sv
// ----------------------------------------------------------------------------
// rpfd_in_if
// Pulse item channel: one pulse or gap duration and the end of train flag.
// ----------------------------------------------------------------------------
interface rpfd_in_if #(
    parameter int unsigned DURATION_WIDTH = 16
);
    logic                      valid;
    logic                      ready;
    logic [DURATION_WIDTH-1:0] pulse_duration;
    logic                      end_of_train;

    modport source (output valid, output pulse_duration, output end_of_train, input ready);
    modport sink   (input valid, input pulse_duration, input end_of_train, output ready);
endinterface

### rtl/rpfd_out_if.sv
// ----------------------------------------------------------------------------
// rpfd_out_if
// Decoded frame channel: frame check flag, device id, unit and direction.
// ----------------------------------------------------------------------------
interface rpfd_out_if;
    import rpfd_pkg::*;

    logic              valid;
    logic              ready;
    logic              frame_ok;
    logic [ID_W-1:0]   device_id;
    logic [UNIT_W-1:0] unit_code;
    logic              direction_up;

    modport source (output valid, output frame_ok, output device_id, output unit_code,
                    output direction_up, input ready);
    modport sink   (input valid, input frame_ok, input device_id, input unit_code,
                    input direction_up, output ready);
endinterface

### rtl/rf_pulse_frame_decoder_unit.sv
// ----------------------------------------------------------------------------
// rf_pulse_frame_decoder_unit
// Decodes a 433 MHz screen remote frame from a train of pulse durations.
// ----------------------------------------------------------------------------
//
//  channel   dir   handshake      payload
//  i_pulse   in    valid/ready    pulse_duration, end_of_train
//  o_frame   out   valid/ready    frame_ok, device_id, unit_code, direction_up
//  i_cfg_*   in    write enable   i_cfg_idx, i_cfg_wdata (no read-back)
//
//  one item per cycle while i_pulse.ready is high; a result shows in the cycle after its ending item
//  the train state (pulse count, stored bits) updates in the accepting cycle
//  one result register; i_pulse.ready = result register empty or being taken
//  reset clears the train state and the result valid flag and loads register defaults
//
module rf_pulse_frame_decoder_unit #(
    parameter int unsigned DURATION_WIDTH = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    rpfd_in_if.sink                          i_pulse,
    rpfd_out_if.source                       o_frame,
    input  logic                             i_cfg_we,
    input  logic [rpfd_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [rpfd_pkg::CFG_DATA_W-1:0]  i_cfg_wdata
);
    import rpfd_pkg::*;

    localparam int unsigned CMP_W =
        (DURATION_WIDTH > CFG_DATA_W) ? DURATION_WIDTH : CFG_DATA_W;

    logic [CFG_DATA_W-1:0] r_bit_threshold;
    logic [CFG_DATA_W-1:0] r_gap_min;
    logic [CFG_DATA_W-1:0] r_gap_max;

    logic [COUNT_W-1:0]    r_count, n_count;
    logic [GROUPS_N-1:0]   r_bits,  n_bits;

    logic                  r_out_valid;
    logic                  r_frame_ok;
    logic [ID_W-1:0]       r_device_id;
    logic [UNIT_W-1:0]     r_unit_code;
    logic                  r_direction_up;

    logic                  take;
    logic                  emit;
    logic [CMP_W-1:0]      dur;
    logic [GROUP_W-1:0]    group;
    logic                  bit_slot;
    logic                  is_one;
    logic                  gap_ok;
    logic                  frame_ok;

    // handshake
    assign i_pulse.ready = !r_out_valid || o_frame.ready;
    assign take          = i_pulse.valid && i_pulse.ready;
    assign emit          = take && i_pulse.end_of_train;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit_threshold <= BIT_THRESHOLD_RST;
            r_gap_min       <= GAP_MIN_RST;
            r_gap_max       <= GAP_MAX_RST;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_BIT_THRESHOLD: r_bit_threshold <= i_cfg_wdata;
                REG_GAP_MIN:       r_gap_min       <= i_cfg_wdata;
                REG_GAP_MAX:       r_gap_max       <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // bit decision on every fourth pulse of groups 0 to 11
    assign dur      = CMP_W'(i_pulse.pulse_duration);
    assign group    = r_count[COUNT_W-1:2];
    assign bit_slot = (r_count[1:0] == 2'b11) && (group <= LAST_GROUP);
    assign is_one   = dur <= CMP_W'(r_bit_threshold);

    always_comb begin
        n_bits = r_bits;
        if (bit_slot) begin
            n_bits[group] = is_one;
        end
    end

    // saturating pulse count
    assign n_count = (r_count < COUNT_SAT) ? r_count + COUNT_W'(1) : r_count;

    // frame check on the ending pulse
    assign gap_ok   = (dur >= CMP_W'(r_gap_min)) && (dur <= CMP_W'(r_gap_max));
    assign frame_ok = (n_count == FRAME_PULSES) && gap_ok;

    // train state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_bits  <= '0;
        end else if (take) begin
            if (i_pulse.end_of_train) begin
                r_count <= '0;
                r_bits  <= '0;
            end else begin
                r_count <= n_count;
                r_bits  <= n_bits;
            end
        end
    end

    // result register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (o_frame.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_frame_ok     <= frame_ok;
            r_unit_code    <= n_bits[UNIT_W-1:0];
            r_device_id    <= n_bits[UNIT_W +: ID_W];
            r_direction_up <= n_bits[LAST_GROUP];
        end
    end

    assign o_frame.valid        = r_out_valid;
    assign o_frame.frame_ok     = r_frame_ok;
    assign o_frame.device_id    = r_device_id;
    assign o_frame.unit_code    = r_unit_code;
    assign o_frame.direction_up = r_direction_up;

endmodule

### rtl/rpfd_checker.sv
// ----------------------------------------------------------------------------
// rpfd_checker
// Port level checks of the rf pulse frame decoder, bound to the top level.
// ----------------------------------------------------------------------------
module rpfd_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_in_end,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic       i_out_ok,
    input logic [4:0] i_out_id,
    input logic [3:0] i_out_unit,
    input logic       i_out_dir
);
    logic in_take;
    logic out_stall;

    assign in_take   = i_in_valid && i_in_ready;
    assign out_stall = i_out_valid && !i_out_ready;

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_stall |=> i_out_valid && $stable(i_out_ok) && $stable(i_out_id) &&
                      $stable(i_out_unit) && $stable(i_out_dir))
        else $error("stalled result changed");

    // an ending item gives a result in the next cycle
    a_end_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_take && i_in_end |=> i_out_valid)
        else $error("ending item gave no result");

    // a result appears only after an ending item
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(in_take && i_in_end))
        else $error("result without ending item");

    // a mid-train item leaves no result behind once the output drains
    a_mid_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_take && !i_in_end && !out_stall |=> !i_out_valid)
        else $error("result after mid-train item");

endmodule

bind rf_pulse_frame_decoder_unit rpfd_checker u_rpfd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_pulse.valid),
    .i_in_ready  (i_pulse.ready),
    .i_in_end    (i_pulse.end_of_train),
    .i_out_valid (o_frame.valid),
    .i_out_ready (o_frame.ready),
    .i_out_ok    (o_frame.frame_ok),
    .i_out_id    (o_frame.device_id),
    .i_out_unit  (o_frame.unit_code),
    .i_out_dir   (o_frame.direction_up)
);

### verif/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench of rf_pulse_frame_decoder_unit. Pulse trains of every
// length are sent through the input channel under several register settings
// and idling patterns; a local frame decoder predicts each result, and every
// result taken from the output channel is compared with the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
    import rpfd_pkg::*;

    localparam int unsigned      DUR_W       = 16;
    localparam logic [DUR_W-1:0] DUR_MAX     = '1;
    localparam int unsigned      CYCLE_LIMIT = 200000;
    localparam int unsigned      HOLD_CYCLES = 400;

    typedef struct packed {
        logic              frame_ok;
        logic [ID_W-1:0]   device_id;
        logic [UNIT_W-1:0] unit_code;
        logic              direction_up;
    } t_frame;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    t_reg_idx              cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    rpfd_in_if #(.DURATION_WIDTH(DUR_W)) pulse_if ();
    rpfd_out_if                          frame_if ();

    rf_pulse_frame_decoder_unit #(
        .DURATION_WIDTH(DUR_W)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pulse     (pulse_if.sink),
        .o_frame     (frame_if.source),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata)
    );

    // decoder copy: registers and train state
    logic [CFG_DATA_W-1:0] dec_threshold = BIT_THRESHOLD_RST;
    logic [CFG_DATA_W-1:0] dec_gap_min   = GAP_MIN_RST;
    logic [CFG_DATA_W-1:0] dec_gap_max   = GAP_MAX_RST;
    logic [COUNT_W-1:0]    dec_count     = '0;
    logic [GROUPS_N-1:0]   dec_bits      = '0;

    t_frame      pending_frames[$];
    int unsigned pulses_sent     = 0;
    int unsigned frames_decoded  = 0;
    int unsigned fail_count      = 0;
    int unsigned cycle_count     = 0;
    int unsigned send_idle_pct   = 0;
    int unsigned recv_idle_pct   = 0;
    int unsigned hold_request    = 0;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("rf_pulse_frame_decoder_unit test failed");
        $finish;
    end

    // decode one accepted item into the expected frame store
    task automatic decode_pulse(input logic [DUR_W-1:0] dur, input logic last);
        t_frame     frame;
        logic [3:0] grp;
        grp = dec_count[COUNT_W-1:2];
        if (dec_count[1:0] == 2'd3 && grp <= LAST_GROUP) begin
            dec_bits[grp] = (dur <= dec_threshold);
        end
        if (dec_count < COUNT_SAT) begin
            dec_count = dec_count + 1'b1;
        end
        if (last) begin
            frame.frame_ok     = (dec_count == FRAME_PULSES) &&
                                 (dur >= dec_gap_min) && (dur <= dec_gap_max);
            frame.device_id    = dec_bits[8:4];
            frame.unit_code    = dec_bits[3:0];
            frame.direction_up = dec_bits[11];
            pending_frames.push_back(frame);
            frames_decoded++;
            dec_count = '0;
            dec_bits  = '0;
        end
    endtask

    // offer one item, with random idle cycles ahead of it
    task automatic send_pulse(input logic [DUR_W-1:0] dur, input logic last);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            pulse_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        pulse_if.valid          <= 1'b1;
        pulse_if.pulse_duration <= dur;
        pulse_if.end_of_train   <= last;
        @(posedge i_clk);
        while (pulse_if.ready !== 1'b1) @(posedge i_clk);
        decode_pulse(dur, last);
        pulses_sent++;
    endtask

    // stop offering and wait until every frame has arrived
    task automatic wait_idle();
        pulse_if.valid <= 1'b0;
        while (pending_frames.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // write all registers in a burst, plus the unused index
    task automatic write_config(input logic [CFG_DATA_W-1:0] thr,
                                input logic [CFG_DATA_W-1:0] gmin,
                                input logic [CFG_DATA_W-1:0] gmax);
        cfg_we    <= 1'b1;
        cfg_idx   <= REG_BIT_THRESHOLD;
        cfg_wdata <= thr;
        @(posedge i_clk);
        cfg_idx   <= REG_GAP_MIN;
        cfg_wdata <= gmin;
        @(posedge i_clk);
        cfg_idx   <= REG_GAP_MAX;
        cfg_wdata <= gmax;
        @(posedge i_clk);
        // writes to the unused index must leave everything alone
        cfg_idx   <= REG_UNUSED;
        cfg_wdata <= CFG_DATA_W'($urandom_range(0, DUR_MAX));
        @(posedge i_clk);
        cfg_we    <= 1'b0;
        dec_threshold = thr;
        dec_gap_min   = gmin;
        dec_gap_max   = gmax;
    endtask

    // random duration, biased toward the extremes
    function automatic logic [DUR_W-1:0] any_duration();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return DUR_MAX;
            default: return DUR_W'($urandom_range(0, DUR_MAX));
        endcase
    endfunction

    // duration that decodes to the given bit, often right at the threshold
    function automatic logic [DUR_W-1:0] bit_duration(input bit one);
        if (one) begin
            if ($urandom_range(0, 7) == 0) return dec_threshold;
            return DUR_W'($urandom_range(0, dec_threshold));
        end
        if (dec_threshold == DUR_MAX) return any_duration();
        if ($urandom_range(0, 7) == 0) return DUR_W'(dec_threshold + 1);
        return DUR_W'($urandom_range(dec_threshold + 1, DUR_MAX));
    endfunction

    // final gap in or out of the accepted window
    function automatic logic [DUR_W-1:0] gap_duration(input bit in_window);
        if (in_window && dec_gap_min <= dec_gap_max) begin
            case ($urandom_range(0, 3))
                0:       return dec_gap_min;
                1:       return dec_gap_max;
                default: return DUR_W'($urandom_range(dec_gap_min, dec_gap_max));
            endcase
        end
        if (dec_gap_max < DUR_MAX && $urandom_range(0, 1) == 1) begin
            return DUR_W'($urandom_range(dec_gap_max + 1, DUR_MAX));
        end
        if (dec_gap_min > 0) return DUR_W'($urandom_range(0, dec_gap_min - 1));
        return any_duration();
    endfunction

    // one train of n items; shaped trains carry real bits and a chosen gap
    task automatic send_train(input int unsigned n, input bit shaped, input bit gap_ok);
        logic [DUR_W-1:0] dur;
        for (int unsigned i = 0; i < n; i++) begin
            if (!shaped)              dur = any_duration();
            else if (i == n - 1)      dur = gap_duration(gap_ok);
            else if (i % 4 == 3)      dur = bit_duration(1'($urandom_range(0, 1)));
            else                      dur = any_duration();
            send_pulse(dur, i == n - 1);
        end
    endtask

    // half well-formed frames, the rest bad-gap frames, short, long or noise trains
    task automatic send_random_trains(input int unsigned item_goal,
                                      input int unsigned frame_goal);
        int unsigned kind;
        while (pulses_sent < item_goal || frames_decoded < frame_goal) begin
            kind = $urandom_range(0, 9);
            if (kind < 6)       send_train(FRAME_PULSES, 1'b1, kind != 0);
            else if (kind == 6) send_train($urandom_range(1, FRAME_PULSES - 1), 1'b1, 1'b1);
            else if (kind == 7) send_train($urandom_range(FRAME_PULSES + 1, 63), 1'b1, 1'b1);
            else if (kind == 8) send_train(FRAME_PULSES, 1'b1, 1'b0);
            else                send_train($urandom_range(1, 60), 1'b0, 1'b0);
        end
    endtask

    // directed trains under the reset register values
    task automatic test_reset_values();
        logic [GROUPS_N-1:0] pattern;
        logic [DUR_W-1:0]    dur;
        // lone ending item: nothing stored, length check fails
        send_pulse('0, 1'b1);
        // ending item on a bit slot, exactly at the threshold
        send_pulse(DUR_MAX, 1'b0);
        send_pulse('0, 1'b0);
        send_pulse(DUR_MAX, 1'b0);
        send_pulse(BIT_THRESHOLD_RST, 1'b1);
        // same, one above the threshold
        send_pulse('0, 1'b0);
        send_pulse(DUR_MAX, 1'b0);
        send_pulse('0, 1'b0);
        send_pulse(DUR_W'(BIT_THRESHOLD_RST + 1), 1'b1);
        // full frame with the gap at the lower bound
        pattern = 12'hA5C;
        for (int unsigned i = 0; i < FRAME_PULSES; i++) begin
            if (i == FRAME_PULSES - 1) dur = GAP_MIN_RST;
            else if (i % 4 == 3)       dur = pattern[i / 4] ? '0 : DUR_MAX;
            else                       dur = (i % 2 == 0) ? '0 : DUR_MAX;
            send_pulse(dur, i == FRAME_PULSES - 1);
        end
        // full frame with inverted bits and the gap at the upper bound
        for (int unsigned i = 0; i < FRAME_PULSES; i++) begin
            if (i == FRAME_PULSES - 1) dur = GAP_MAX_RST;
            else if (i % 4 == 3)       dur = pattern[i / 4] ? DUR_MAX : '0;
            else                       dur = (i % 2 == 0) ? DUR_MAX : '0;
            send_pulse(dur, i == FRAME_PULSES - 1);
        end
        wait_idle();
    endtask

    // widest window, lowest threshold; sender idles less than receiver
    task automatic test_open_window();
        write_config('0, '0, DUR_MAX);
        send_idle_pct = 37;
        recv_idle_pct = 69;
        send_random_trains(pulses_sent + 250, 0);
        wait_idle();
    endtask

    // highest threshold, single-value window at the top; roles swapped
    task automatic test_top_window();
        write_config(DUR_MAX, DUR_MAX, DUR_MAX);
        send_idle_pct = 69;
        recv_idle_pct = 37;
        send_random_trains(pulses_sent + 250, 0);
        wait_idle();
    endtask

    // receiver holds off long while short trains keep coming
    task automatic test_backpressure();
        int unsigned start;
        write_config(CFG_DATA_W'($urandom_range(0, DUR_MAX)), 16'd30000, 16'd10000);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_request  = HOLD_CYCLES;
        start = pulses_sent;
        while (pulses_sent < start + 40) begin
            send_train($urandom_range(1, 4), 1'b1, 1'b1);
        end
        wait_idle();
    endtask

    // random registers, no idling on either side
    task automatic test_random_config();
        logic [CFG_DATA_W-1:0] lo;
        logic [CFG_DATA_W-1:0] hi;
        lo = CFG_DATA_W'($urandom_range(0, DUR_MAX));
        hi = CFG_DATA_W'($urandom_range(lo, DUR_MAX));
        write_config(CFG_DATA_W'($urandom_range(0, DUR_MAX)), lo, hi);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_random_trains(pulses_sent + 250, 0);
        wait_idle();
    endtask

    // receiver ready, with an optional long hold-off
    initial begin : frame_receiver
        int unsigned hold_left;
        hold_left = 0;
        frame_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request != 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left != 0) begin
                frame_if.ready <= 1'b0;
                hold_left--;
            end else begin
                frame_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    // compare each taken frame with the oldest prediction
    initial begin : frame_checker
        t_frame want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n === 1'b1 && frame_if.valid === 1'b1 && frame_if.ready === 1'b1) begin
                if (pending_frames.size() == 0) begin
                    $error("frame with no prediction waiting");
                    fail_count++;
                end else begin
                    want = pending_frames.pop_front();
                    check_field("frame_ok", 8'(want.frame_ok), 8'(frame_if.frame_ok));
                    check_field("device_id", 8'(want.device_id), 8'(frame_if.device_id));
                    check_field("unit_code", 8'(want.unit_code), 8'(frame_if.unit_code));
                    check_field("direction_up", 8'(want.direction_up),
                                8'(frame_if.direction_up));
                end
            end
        end
    end

    // test sequence
    initial begin
        i_rst_n                 = 1'b0;
        cfg_we                  = 1'b0;
        cfg_idx                 = REG_BIT_THRESHOLD;
        cfg_wdata               = '0;
        pulse_if.valid          = 1'b0;
        pulse_if.pulse_duration = '0;
        pulse_if.end_of_train   = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_values();
        test_open_window();
        test_top_window();
        test_backpressure();
        test_random_config();

        if (pending_frames.size() != 0) begin
            $error("%0d predicted frames never arrived", pending_frames.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("rf_pulse_frame_decoder_unit test passed");
        end else begin
            $display("rf_pulse_frame_decoder_unit test failed");
        end
        $finish;
    end

endmodule

### sim.f
rtl/rpfd_pkg.sv
rtl/rpfd_in_if.sv
rtl/rpfd_out_if.sv
rtl/rf_pulse_frame_decoder_unit.sv
rtl/rpfd_checker.sv
verif/tb.sv
